@@ hw/rtl/tdp_pkg.sv @@
package tdp_pkg;

  localparam int ON_DEPTH_DEF  = 16;
  localparam int OFF_DEPTH_DEF = 16;

  localparam logic [23:0] CYCLE_LENGTH_RST = 24'd1000000;
  localparam logic [15:0] TICK_STEP_RST    = 16'd320;

  localparam logic CFG_CYCLE_LENGTH = 1'b0;
  localparam logic CFG_TICK_STEP    = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_PUBLISH = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_FLUSH   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_ON       = 2'd0,
    KIND_OFF      = 2'd1,
    KIND_REJECT   = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_CHK,
    S_LD_RD,
    S_LD_CMP,
    S_SH_RD,
    S_SH_WR,
    S_LD_WR,
    S_TK_ADV,
    S_DS_RD,
    S_DS_CMP,
    S_DS_PARK,
    S_DS_OVF,
    S_DEC,
    S_MIN,
    S_OFF_EMIT,
    S_CYC_END,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [15:0] value;
    logic [23:0] hold;
    logic [23:0] start;
  } ev_t;

endpackage

@@ hw/rtl/timed_event_dispatcher.sv @@
// Channel  Dir  Handshake          Payload
// in_      in   in_tvalid/tready   tuser: action; tdata: event_start, hold_time, event_value
// out_     out  out_tvalid/tready  tuser: kind; tdata: value_out, cycle count; tlast: last
// cfg_     in   cfg_we             cfg_addr: register index; cfg_wdata: data
//
// One item at a time; in_tready is high only while the sequencer idles; a publish never leaves idle.
// Load: scan the write side for the insertion point, shift later events up, then write;
//   a reject emits one result. Tick: advance time, dispatch due note-ons (parking holds
//   in the off table or reporting overflow), count the off table down, then emit
//   note-offs by smallest remaining time. Flush emits every parked note-off the same way.
// Reset is synchronous, active low; a stalled output holds the sequencer.
module timed_event_dispatcher #(
  parameter int ON_DEPTH  = tdp_pkg::ON_DEPTH_DEF,
  parameter int OFF_DEPTH = tdp_pkg::OFF_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // event_start[23:0], hold_time[47:24], event_value[63:48]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // value_out[15:0], cycle count[47:16]
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [23:0] cfg_wdata
);

  localparam int AW = $clog2(2 * ON_DEPTH);
  localparam int CW = $clog2(ON_DEPTH + 1);
  localparam int OW = $clog2(OFF_DEPTH);

  tdp_pkg::state_t state_r, state_nxt;

  logic [23:0] cycle_length_r;
  logic [15:0] tick_step_r;

  tdp_pkg::action_t act_r;
  logic [23:0] start_r, hold_r;
  logic [15:0] val_r;

  logic          read_side_r, read_side_nxt;
  logic [CW-1:0] cnt_r [2];
  logic [CW-1:0] cnt_nxt [2];
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [24:0]   elapsed_r, elapsed_nxt;
  logic [31:0]   cyc_r, cyc_nxt;
  logic [CW-1:0] k_r, k_nxt, pos_r, pos_nxt, j_r, j_nxt;

  // event memory
  tdp_pkg::ev_t ev_mem [2*ON_DEPTH];
  tdp_pkg::ev_t mem_rdata, mem_wdata;
  logic         mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;

  // off table
  logic signed [24:0] off_rem [OFF_DEPTH];
  logic [15:0]        off_tag [OFF_DEPTH];
  logic [OFF_DEPTH-1:0] valid_r, valid_nxt, expired_r, expired_nxt;
  logic               off_we;
  logic [OW-1:0]      off_waddr;
  logic signed [24:0] off_wrem;
  logic [15:0]        off_wtag;
  logic [OW-1:0]      oi_r, oi_nxt;
  logic               best_v_r, best_v_nxt;
  logic signed [24:0] best_rem_r, best_rem_nxt;
  logic [OW-1:0]      best_idx_r, best_idx_nxt;
  logic [15:0]        best_tag_r, best_tag_nxt;

  logic          free_any;
  logic [OW-1:0] free_slot;

  // pending result and output register
  logic        pend_v_r;
  tdp_pkg::kind_t pend_kind_r;
  logic [15:0] pend_val_r;
  logic [31:0] pend_cyc_r;
  logic        out_v_r, out_last_r;
  tdp_pkg::kind_t out_kind_r;
  logic [15:0] out_val_r;
  logic [31:0] out_cyc_r;

  logic           emit_req, emit_fire, out_free, fin_push, push;
  tdp_pkg::kind_t emit_kind;
  logic [15:0]    emit_val;

  logic           wside;
  logic           in_fire;
  logic           ld_reject;
  logic           ptr_in;
  logic           ev_due;
  logic           oi_last;
  logic           cyc_end;
  logic signed [24:0] cur_rem;
  logic [15:0]    cur_tag;

  function automatic logic [AW-1:0] mem_addr(input logic side, input logic [CW-1:0] idx);
    mem_addr = side ? AW'(ON_DEPTH) + AW'(idx) : AW'(idx);
  endfunction

  assign in_tready = (state_r == tdp_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign wside     = ~read_side_r;
  assign ld_reject = (start_r >= cycle_length_r) || (cnt_r[wside] >= CW'(ON_DEPTH));
  assign ptr_in    = ptr_r < cnt_r[read_side_r];
  assign ev_due    = elapsed_r >= {1'b0, mem_rdata.start};
  assign oi_last   = oi_r == OW'(OFF_DEPTH - 1);
  assign cyc_end   = elapsed_r >= {1'b0, cycle_length_r};
  assign cur_rem   = off_rem[oi_r];
  assign cur_tag   = off_tag[oi_r];

  assign out_free  = !out_v_r || out_tready;
  assign emit_fire = emit_req && (!pend_v_r || out_free);
  assign fin_push  = (state_r == tdp_pkg::S_FIN) && pend_v_r && out_free;
  assign push      = (emit_fire && pend_v_r) || fin_push;

  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = OFF_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any  = 1'b1;
        free_slot = OW'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tdp_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (tdp_pkg::action_t'(in_tuser))
            tdp_pkg::ACT_LOAD:    state_nxt = tdp_pkg::S_LD_CHK;
            tdp_pkg::ACT_PUBLISH: state_nxt = tdp_pkg::S_IDLE;
            tdp_pkg::ACT_TICK:    state_nxt = tdp_pkg::S_TK_ADV;
            tdp_pkg::ACT_FLUSH:   state_nxt = tdp_pkg::S_MIN;
            default:              state_nxt = tdp_pkg::S_IDLE;
          endcase
        end
      end
      tdp_pkg::S_LD_CHK: begin
        if (!ld_reject) state_nxt = tdp_pkg::S_LD_RD;
        else if (emit_fire) state_nxt = tdp_pkg::S_FIN;
      end
      tdp_pkg::S_LD_RD:
        state_nxt = (k_r < cnt_r[wside]) ? tdp_pkg::S_LD_CMP : tdp_pkg::S_SH_RD;
      tdp_pkg::S_LD_CMP:
        state_nxt = (mem_rdata.start <= start_r) ? tdp_pkg::S_LD_RD : tdp_pkg::S_SH_RD;
      tdp_pkg::S_SH_RD:
        state_nxt = (j_r > pos_r) ? tdp_pkg::S_SH_WR : tdp_pkg::S_LD_WR;
      tdp_pkg::S_SH_WR:  state_nxt = tdp_pkg::S_SH_RD;
      tdp_pkg::S_LD_WR:  state_nxt = tdp_pkg::S_FIN;
      tdp_pkg::S_TK_ADV: state_nxt = tdp_pkg::S_DS_RD;
      tdp_pkg::S_DS_RD:  state_nxt = ptr_in ? tdp_pkg::S_DS_CMP : tdp_pkg::S_DEC;
      tdp_pkg::S_DS_CMP: begin
        if (!ev_due) state_nxt = tdp_pkg::S_DEC;
        else if (emit_fire)
          state_nxt = (mem_rdata.hold != '0) ? tdp_pkg::S_DS_PARK : tdp_pkg::S_DS_RD;
      end
      tdp_pkg::S_DS_PARK: state_nxt = free_any ? tdp_pkg::S_DS_RD : tdp_pkg::S_DS_OVF;
      tdp_pkg::S_DS_OVF:  if (emit_fire) state_nxt = tdp_pkg::S_DS_RD;
      tdp_pkg::S_DEC:     if (oi_last) state_nxt = tdp_pkg::S_MIN;
      tdp_pkg::S_MIN:     if (oi_last) state_nxt = tdp_pkg::S_OFF_EMIT;
      tdp_pkg::S_OFF_EMIT: begin
        if (best_v_r) begin
          if (emit_fire) state_nxt = tdp_pkg::S_MIN;
        end else begin
          state_nxt = (act_r == tdp_pkg::ACT_TICK) ? tdp_pkg::S_CYC_END : tdp_pkg::S_FIN;
        end
      end
      tdp_pkg::S_CYC_END: state_nxt = tdp_pkg::S_FIN;
      tdp_pkg::S_FIN:     if (!pend_v_r || out_free) state_nxt = tdp_pkg::S_IDLE;
      default:            state_nxt = tdp_pkg::S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    read_side_nxt = read_side_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    elapsed_nxt   = elapsed_r;
    cyc_nxt       = cyc_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    j_nxt         = j_r;
    valid_nxt     = valid_r;
    expired_nxt   = expired_r;
    oi_nxt        = oi_r;
    best_v_nxt    = best_v_r;
    best_rem_nxt  = best_rem_r;
    best_idx_nxt  = best_idx_r;
    best_tag_nxt  = best_tag_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = '0;
    mem_raddr     = '0;
    mem_wdata     = mem_rdata;
    off_we        = 1'b0;
    off_waddr     = oi_r;
    off_wrem      = cur_rem;
    off_wtag      = cur_tag;
    emit_req      = 1'b0;
    emit_kind     = tdp_pkg::KIND_ON;
    emit_val      = mem_rdata.value;

    unique case (state_r)
      tdp_pkg::S_IDLE: begin
        if (in_fire) begin
          if (tdp_pkg::action_t'(in_tuser) == tdp_pkg::ACT_PUBLISH)
            read_side_nxt = ~read_side_r;
          expired_nxt = valid_r;
          oi_nxt      = '0;
          best_v_nxt  = 1'b0;
        end
      end
      tdp_pkg::S_LD_CHK: begin
        k_nxt = '0;
        if (ld_reject) begin
          emit_req  = 1'b1;
          emit_kind = tdp_pkg::KIND_REJECT;
          emit_val  = val_r;
        end
      end
      tdp_pkg::S_LD_RD: begin
        if (k_r < cnt_r[wside]) begin
          mem_re    = 1'b1;
          mem_raddr = mem_addr(wside, k_r);
        end else begin
          pos_nxt = k_r;
          j_nxt   = cnt_r[wside];
        end
      end
      tdp_pkg::S_LD_CMP: begin
        if (mem_rdata.start <= start_r) begin
          k_nxt = k_r + 1'b1;
        end else begin
          pos_nxt = k_r;
          j_nxt   = cnt_r[wside];
        end
      end
      tdp_pkg::S_SH_RD: begin
        if (j_r > pos_r) begin
          mem_re    = 1'b1;
          mem_raddr = mem_addr(wside, j_r - 1'b1);
        end
      end
      tdp_pkg::S_SH_WR: begin
        // move one entry up to open the insertion slot
        mem_we    = 1'b1;
        mem_waddr = mem_addr(wside, j_r);
        j_nxt     = j_r - 1'b1;
      end
      tdp_pkg::S_LD_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = mem_addr(wside, pos_r);
        mem_wdata       = '{value: val_r, hold: hold_r, start: start_r};
        cnt_nxt[wside]  = cnt_r[wside] + 1'b1;
      end
      tdp_pkg::S_TK_ADV: begin
        elapsed_nxt = elapsed_r + {9'b0, tick_step_r};
        expired_nxt = '0;
        oi_nxt      = '0;
      end
      tdp_pkg::S_DS_RD: begin
        if (ptr_in) begin
          mem_re    = 1'b1;
          mem_raddr = mem_addr(read_side_r, ptr_r);
        end
      end
      tdp_pkg::S_DS_CMP: begin
        if (ev_due) begin
          emit_req = 1'b1;
          if (emit_fire && mem_rdata.hold == '0) ptr_nxt = ptr_r + 1'b1;
        end
      end
      tdp_pkg::S_DS_PARK: begin
        if (free_any) begin
          off_we               = 1'b1;
          off_waddr            = free_slot;
          off_wrem             = signed'({1'b0, mem_rdata.hold});
          off_wtag             = mem_rdata.value;
          valid_nxt[free_slot] = 1'b1;
          ptr_nxt              = ptr_r + 1'b1;
        end
      end
      tdp_pkg::S_DS_OVF: begin
        emit_req  = 1'b1;
        emit_kind = tdp_pkg::KIND_OVERFLOW;
        if (emit_fire) ptr_nxt = ptr_r + 1'b1;
      end
      tdp_pkg::S_DEC: begin
        // expire entries at or below zero, count the rest down
        if (valid_r[oi_r]) begin
          if (cur_rem <= 25'sd0) begin
            expired_nxt[oi_r] = 1'b1;
          end else begin
            off_we   = 1'b1;
            off_wrem = cur_rem - signed'({9'b0, tick_step_r});
          end
        end
        oi_nxt = oi_last ? '0 : oi_r + 1'b1;
        if (oi_last) best_v_nxt = 1'b0;
      end
      tdp_pkg::S_MIN: begin
        if (expired_r[oi_r] && (!best_v_r || cur_rem < best_rem_r)) begin
          best_v_nxt   = 1'b1;
          best_rem_nxt = cur_rem;
          best_idx_nxt = oi_r;
          best_tag_nxt = cur_tag;
        end
        oi_nxt = oi_last ? '0 : oi_r + 1'b1;
      end
      tdp_pkg::S_OFF_EMIT: begin
        if (best_v_r) begin
          emit_req  = 1'b1;
          emit_kind = tdp_pkg::KIND_OFF;
          emit_val  = best_tag_r;
          if (emit_fire) begin
            expired_nxt[best_idx_r] = 1'b0;
            valid_nxt[best_idx_r]   = 1'b0;
            best_v_nxt              = 1'b0;
            oi_nxt                  = '0;
          end
        end
      end
      tdp_pkg::S_CYC_END: begin
        if (cyc_end) begin
          cnt_nxt[read_side_r] = '0;
          ptr_nxt              = '0;
          elapsed_nxt          = '0;
          cyc_nxt              = cyc_r + 1'b1;
        end
      end
      tdp_pkg::S_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) ev_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= ev_mem[mem_raddr];
    if (off_we) begin
      off_rem[off_waddr] <= off_wrem;
      off_tag[off_waddr] <= off_wtag;
    end
    if (in_fire) begin
      act_r   <= tdp_pkg::action_t'(in_tuser);
      start_r <= in_tdata[23:0];
      hold_r  <= in_tdata[47:24];
      val_r   <= in_tdata[63:48];
    end
    k_r          <= k_nxt;
    pos_r        <= pos_nxt;
    j_r          <= j_nxt;
    oi_r         <= oi_nxt;
    best_rem_r   <= best_rem_nxt;
    best_idx_r   <= best_idx_nxt;
    best_tag_r   <= best_tag_nxt;
    expired_r    <= expired_nxt;
    if (emit_fire) begin
      pend_kind_r <= emit_kind;
      pend_val_r  <= emit_val;
      pend_cyc_r  <= cyc_r;
    end
    if (push) begin
      out_kind_r <= pend_kind_r;
      out_val_r  <= pend_val_r;
      out_cyc_r  <= pend_cyc_r;
      out_last_r <= fin_push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= tdp_pkg::S_IDLE;
      cycle_length_r <= tdp_pkg::CYCLE_LENGTH_RST;
      tick_step_r    <= tdp_pkg::TICK_STEP_RST;
      read_side_r    <= 1'b0;
      cnt_r[0]       <= '0;
      cnt_r[1]       <= '0;
      ptr_r          <= '0;
      elapsed_r      <= '0;
      cyc_r          <= '0;
      valid_r        <= '0;
      best_v_r       <= 1'b0;
      pend_v_r       <= 1'b0;
      out_v_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      read_side_r <= read_side_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      elapsed_r   <= elapsed_nxt;
      cyc_r       <= cyc_nxt;
      valid_r     <= valid_nxt;
      best_v_r    <= best_v_nxt;
      if (cfg_we) begin
        if (cfg_addr == tdp_pkg::CFG_CYCLE_LENGTH) cycle_length_r <= cfg_wdata;
        else tick_step_r <= cfg_wdata[15:0];
      end
      if (emit_fire) pend_v_r <= 1'b1;
      else if (fin_push) pend_v_r <= 1'b0;
      if (push) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_cyc_r, out_val_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !pend_v_r)
    else $error("pending result left behind at idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= CW'(ON_DEPTH) && cnt_r[1] <= CW'(ON_DEPTH))
    else $error("event buffer count beyond depth");

  a_publish_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser == tdp_pkg::ACT_PUBLISH |=> in_tready)
    else $error("publish did not return to idle");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    fin_push |=> out_tvalid && out_tlast)
    else $error("final result not marked last");
`endif

endmodule

@@ tb/sv/tdp_checker.sv @@
module tdp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // event_start[23:0], hold_time[47:24], event_value[63:48]
  input  logic [1:0]  in_tuser,   // action[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // value_out[15:0], cycle count[47:16]
  input  logic [1:0]  out_tuser,  // kind[1:0]
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [23:0] cfg_wdata,
  output int          errors,
  output int          pending,
  output int          checked
);

  localparam int NEV  = tdp_pkg::ON_DEPTH_DEF;
  localparam int NOFF = tdp_pkg::OFF_DEPTH_DEF;

  typedef struct {
    tdp_pkg::kind_t kind;
    logic [15:0]    tag;
    logic [31:0]    cyc;
    logic           last;
  } note_t;

  note_t        notes_due[$];
  logic [23:0]  cyc_len;
  logic [15:0]  step;
  tdp_pkg::ev_t sides[2][NEV];
  int           side_cnt[2];
  logic         rd_side;
  int           disp_ptr;
  logic [24:0]  elapsed;
  logic [31:0]  cyc_cnt;
  int           off_left[NOFF];
  logic [15:0]  off_tag[NOFF];
  logic         off_busy[NOFF];

  task automatic report(input string what);
    $display("MISMATCH t=%0t %s", $time, what);
    errors++;
  endtask

  function automatic void add_note(input tdp_pkg::kind_t k, input logic [15:0] tag);
    note_t n;
    n.kind = k;
    n.tag  = tag;
    n.cyc  = cyc_cnt;
    n.last = 1'b0;
    notes_due = {notes_due, n};
  endfunction

  // drain picked entries, smallest remaining time first, ties by slot
  function automatic void release_offs(input logic pick[NOFF]);
    int best;
    forever begin
      best = -1;
      for (int i = 0; i < NOFF; i++)
        if (pick[i] && (best < 0 || off_left[i] < off_left[best])) best = i;
      if (best < 0) break;
      add_note(tdp_pkg::KIND_OFF, off_tag[best]);
      pick[best] = 1'b0;
      off_busy[best] = 1'b0;
    end
  endfunction

  function automatic void insert_event(input tdp_pkg::ev_t e);
    int w;
    int pos;
    w = !rd_side;
    if (e.start >= cyc_len || side_cnt[w] >= NEV) begin
      add_note(tdp_pkg::KIND_REJECT, e.value);
      return;
    end
    pos = 0;
    while (pos < side_cnt[w] && sides[w][pos].start <= e.start) pos++;
    for (int k = side_cnt[w]; k > pos; k--) sides[w][k] = sides[w][k-1];
    sides[w][pos] = e;
    side_cnt[w]++;
  endfunction

  function automatic void advance_tick();
    int           r;
    int           slot;
    tdp_pkg::ev_t e;
    logic         due[NOFF];
    r = rd_side;
    elapsed = elapsed + 25'(step);
    while (disp_ptr < side_cnt[r]) begin
      e = sides[r][disp_ptr];
      if (elapsed < 25'(e.start)) break;
      add_note(tdp_pkg::KIND_ON, e.value);
      if (e.hold != 0) begin
        slot = -1;
        for (int i = 0; i < NOFF; i++)
          if (!off_busy[i] && slot < 0) slot = i;
        if (slot < 0) add_note(tdp_pkg::KIND_OVERFLOW, e.value);
        else begin
          off_busy[slot] = 1'b1;
          off_left[slot] = int'(e.hold);
          off_tag[slot]  = e.value;
        end
      end
      disp_ptr++;
    end
    for (int i = 0; i < NOFF; i++) begin
      due[i] = off_busy[i] && off_left[i] <= 0;
      if (off_busy[i] && !due[i]) off_left[i] -= int'(step);
    end
    release_offs(due);
    if (elapsed >= 25'(cyc_len)) begin
      side_cnt[r] = 0;
      disp_ptr = 0;
      elapsed = '0;
      cyc_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    int           before_n;
    tdp_pkg::ev_t e;
    note_t        n;
    logic         all[NOFF];
    if (!rst_n) begin
      notes_due.delete();
      errors   = 0;
      checked  = 0;
      cyc_len  = tdp_pkg::CYCLE_LENGTH_RST;
      step     = tdp_pkg::TICK_STEP_RST;
      side_cnt = '{0, 0};
      rd_side  = 1'b0;
      disp_ptr = 0;
      elapsed  = '0;
      cyc_cnt  = '0;
      for (int i = 0; i < NOFF; i++) off_busy[i] = 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == tdp_pkg::CFG_CYCLE_LENGTH) cyc_len = cfg_wdata;
        else step = cfg_wdata[15:0];
      end
      if (out_tvalid && out_tready) begin
        checked++;
        if (notes_due.size() == 0) report("result transfer with nothing expected");
        else begin
          n = notes_due.pop_front();
          if (tdp_pkg::kind_t'(out_tuser) != n.kind)
            report($sformatf("kind %0d, expected %0d", out_tuser, n.kind));
          if (out_tdata[15:0] != n.tag)
            report($sformatf("value %h, expected %h", out_tdata[15:0], n.tag));
          if (out_tdata[47:16] != n.cyc)
            report($sformatf("cycle %0d, expected %0d", out_tdata[47:16], n.cyc));
          if (out_tlast != n.last)
            report($sformatf("last %b, expected %b", out_tlast, n.last));
        end
      end
      if (in_tvalid && in_tready) begin
        before_n = notes_due.size();
        e = tdp_pkg::ev_t'({in_tdata[63:48], in_tdata[47:24], in_tdata[23:0]});
        case (tdp_pkg::action_t'(in_tuser))
          tdp_pkg::ACT_LOAD:    insert_event(e);
          tdp_pkg::ACT_PUBLISH: rd_side = !rd_side;
          tdp_pkg::ACT_TICK:    advance_tick();
          default: begin
            all = off_busy;
            release_offs(all);
          end
        endcase
        if (notes_due.size() > before_n) notes_due[$].last = 1'b1;
      end
    end
    pending = notes_due.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
module testbench;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid, out_tready;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic        cfg_addr;
  logic [23:0] cfg_wdata;
  int          errors, pending, checked;
  int          sent = 0;
  int          reg_writes = 0;
  int          quiet = 0;
  bit          no_gaps = 0;
  logic [23:0] cur_len = tdp_pkg::CYCLE_LENGTH_RST;
  logic [15:0] cur_step = tdp_pkg::TICK_STEP_RST;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  timed_event_dispatcher dut (.*);

  tdp_checker chk (.*);

  function automatic int draw_wait();
    return no_gaps ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic send(input tdp_pkg::action_t act, input logic [23:0] start,
                      input logic [23:0] hold, input logic [15:0] tag);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {tag, hold, start};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // hold off the sender until the block has delivered everything and gone quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
    if (idx == tdp_pkg::CFG_CYCLE_LENGTH) cur_len = val;
    else cur_step = val[15:0];
  endtask

  function automatic logic [23:0] pick_hold();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 24'(24'(cur_step) * $urandom_range(1, 8));
      2: return 24'($urandom_range(1, 24'hFFFFFF));
      default: return 24'(24'(cur_step) * $urandom_range(1, 3) + $urandom_range(0, 400));
    endcase
  endfunction

  function automatic logic [23:0] pick_start();
    if ($urandom_range(0, 9) == 0) return 24'($urandom_range(0, 24'hFFFFFF));
    return 24'($urandom_range(0, cur_len - 1));
  endfunction

  // one scheduling round: fill the write side, publish, tick through the cycle (at most 40 ticks)
  task automatic round();
    int n;
    int ticks;
    n = $urandom_range(1, 17);
    for (int i = 0; i < n; i++)
      send(tdp_pkg::ACT_LOAD, pick_start(), pick_hold(), 16'($urandom));
    if ($urandom_range(0, 7) == 0)
      send(tdp_pkg::action_t'($urandom_range(0, 3)), 24'($urandom), 24'($urandom),
           16'($urandom));
    send(tdp_pkg::ACT_PUBLISH, 24'($urandom), 24'($urandom), 16'($urandom));
    ticks = cur_len / cur_step + 2;
    if (ticks > 40) ticks = $urandom_range(10, 40);
    for (int i = 0; i < ticks; i++)
      send(tdp_pkg::ACT_TICK, 24'($urandom), 24'($urandom), 16'($urandom));
    if ($urandom_range(0, 3) == 0)
      send(tdp_pkg::ACT_FLUSH, 24'($urandom), 24'($urandom), 16'($urandom));
  endtask

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= 5000) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: after each result transfer, drop ready for a random stall unless no_gaps is set
  initial begin
    int s;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        s = draw_wait();
        if (s > 0) begin
          out_tready <= 1'b0;
          repeat (s) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int cl;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= tdp_pkg::ACT_LOAD;
    cfg_we    <= 1'b0;
    cfg_addr  <= tdp_pkg::CFG_CYCLE_LENGTH;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ties, bounds, empty holds, longest holds, reject paths
    write_reg(tdp_pkg::CFG_CYCLE_LENGTH, 24'd2000);
    write_reg(tdp_pkg::CFG_TICK_STEP, 24'd320);
    send(tdp_pkg::ACT_FLUSH, '0, '0, '0);
    send(tdp_pkg::ACT_TICK, '0, '0, '0);
    send(tdp_pkg::ACT_LOAD, 24'd0, 24'd320, 16'h0000);
    send(tdp_pkg::ACT_LOAD, 24'd0, 24'd0, 16'hFFFF);
    send(tdp_pkg::ACT_LOAD, 24'd640, 24'hFFFFFF, 16'h1234);
    send(tdp_pkg::ACT_LOAD, 24'd1999, 24'd1, 16'h00A5);
    send(tdp_pkg::ACT_LOAD, 24'd2000, 24'd5, 16'hBEEF);
    send(tdp_pkg::ACT_LOAD, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    send(tdp_pkg::ACT_PUBLISH, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    for (int i = 0; i < 8; i++) send(tdp_pkg::ACT_TICK, '0, '0, '0);
    send(tdp_pkg::ACT_FLUSH, '0, '0, '0);
    send(tdp_pkg::ACT_PUBLISH, '0, '0, '0);
    drain();

    // extremes of both registers
    write_reg(tdp_pkg::CFG_CYCLE_LENGTH, 24'd1);
    write_reg(tdp_pkg::CFG_TICK_STEP, 24'd65535);
    no_gaps = 1;
    for (int i = 0; i < 17; i++) send(tdp_pkg::ACT_LOAD, 24'd0, 24'hFFFFFF, 16'(i));
    send(tdp_pkg::ACT_PUBLISH, '0, '0, '0);
    send(tdp_pkg::ACT_TICK, '0, '0, '0);
    send(tdp_pkg::ACT_FLUSH, '0, '0, '0);
    drain();
    no_gaps = 0;
    write_reg(tdp_pkg::CFG_CYCLE_LENGTH, 24'hFFFFFF);
    write_reg(tdp_pkg::CFG_TICK_STEP, 24'd1);
    send(tdp_pkg::ACT_LOAD, 24'd0, 24'd2, 16'h5A5A);
    send(tdp_pkg::ACT_PUBLISH, '0, '0, '0);
    for (int i = 0; i < 4; i++) send(tdp_pkg::ACT_TICK, '0, '0, '0);
    drain();

    while (sent < 370) begin
      case ($urandom_range(0, 5))
        0: begin
          write_reg(tdp_pkg::CFG_CYCLE_LENGTH, 24'hFFFFFF);
          write_reg(tdp_pkg::CFG_TICK_STEP, 24'd65535);
        end
        1: begin
          write_reg(tdp_pkg::CFG_CYCLE_LENGTH, 24'd1);
          write_reg(tdp_pkg::CFG_TICK_STEP, 24'($urandom_range(1, 65535)));
        end
        default: begin
          write_reg(tdp_pkg::CFG_TICK_STEP, 24'($urandom_range(1, 2000)));
          cl = cur_step * $urandom_range(2, 20) + $urandom_range(0, 300);
          write_reg(tdp_pkg::CFG_CYCLE_LENGTH, 24'(cl));
        end
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) round();
      drain();
    end

    $display("covered %0d input transfers, %0d results checked, %0d register writes",
             sent, checked, reg_writes);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
